// File: hw/rtl/fixed_point_square_root_macros.svh
// assertion macros shared by the block's checker
`ifndef FIXED_POINT_SQUARE_ROOT_MACROS_SVH
`define FIXED_POINT_SQUARE_ROOT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FPSQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_square_root: assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define FPSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed_point_square_root: assertion failed");

`endif

// File: hw/rtl/fpsq_pkg.sv
`timescale 1ns / 1ps

package fpsq_pkg;

    // number format of the radicand
    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    // width of the root field
    localparam int OUT_W = 25;

    // magnitude scaled by 2^FRAC_BITS, taken two bits per cell
    localparam int SCALED_W = DATA_WIDTH - 1 + FRAC_BITS;
    localparam int PAIRS    = (SCALED_W + 1) / 2;
    localparam int RAD_W    = 2 * PAIRS;
    localparam int ROOT_W   = PAIRS;
    localparam int REM_W    = PAIRS + 2;

    // cycles from accept edge to the cycle the result strobe is high
    localparam int LATENCY = PAIRS + 1;

    // -1.0 in the output format
    localparam logic signed [OUT_W-1:0] NEG_ONE = OUT_W'(-(2 ** FRAC_BITS));

    // word travelling down the chain of cells
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } fpsq_cell_t;

endpackage

// File: hw/rtl/fpsq_cell.sv
`timescale 1ns / 1ps

module fpsq_cell
    import fpsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fpsq_cell_t cell_in,
    output fpsq_cell_t cell_out
);

    fpsq_cell_t           cell_reg;
    fpsq_cell_t           cell_next;
    logic [REM_W+1:0]     acc;
    logic [REM_W+1:0]     trial;

    // one restoring root step: bring down two bits, try 4*root+1
    always_comb
    begin
        acc   = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
        trial = (REM_W + 2)'({cell_in.root, 2'b01});
        cell_next       = cell_in;
        cell_next.rad   = cell_in.rad << 2;
        if (acc >= trial)
        begin
            cell_next.rem  = REM_W'(acc - trial);
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = REM_W'(acc);
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    // cell register, emptied by reset, moves on every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: hw/rtl/fixed_point_square_root.sv
`timescale 1ns / 1ps
// Fixed-point square root, signed Q16.16 in, signed Q9.16 out.
// Input: a word is taken at a rising edge where start is high and busy is low;
//   radicand is sampled at that edge.
// Output: done is high for exactly one cycle with root_value and
//   negative_error; the receiver must take the word in that cycle.
// root_value is floor(sqrt(radicand * 2^16)); a negative radicand gives
//   -1.0 (-65536) with negative_error set, and zero gives zero.
// The root is formed by a chain of 24 cells, each resolving one root bit
//   from two bits of the scaled 48-bit radicand per cycle.
// done is registered from the output of the last cell.
// A new word cannot enter while busy is high; busy drops once the word has
//   reached the last cell, so the next word can enter behind it.
// Reset (rst_n low, asynchronous) empties the chain and clears done and busy;
//   a word in flight is dropped.
// The receiver cannot stall the block, so no back pressure exists.
module fixed_point_square_root
    import fpsq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [DATA_WIDTH-1:0]  radicand,
    output logic                          done,
    output logic signed [OUT_W-1:0]       root_value,
    output logic                          negative_error
);

    fpsq_cell_t               link [PAIRS+1];
    logic [PAIRS-2:0]         early_valid;
    logic                     done_reg;
    logic signed [OUT_W-1:0]  root_value_reg;
    logic                     negative_error_reg;

    // head of the chain: magnitude scaled by 2^FRAC_BITS
    always_comb
    begin
        link[0].valid = start && !busy;
        link[0].neg   = radicand[DATA_WIDTH-1];
        link[0].rad   = RAD_W'({radicand[DATA_WIDTH-2:0], {FRAC_BITS{1'b0}}});
        link[0].rem   = '0;
        link[0].root  = '0;
    end

    // chain of root cells
    for (genvar i = 0; i < PAIRS; i++)
    begin : g_cell
        fpsq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (link[i]),
            .cell_out (link[i+1])
        );
    end

    // busy while a word sits in any cell but the last
    for (genvar i = 0; i < PAIRS - 1; i++)
    begin : g_busy
        assign early_valid[i] = link[i+1].valid;
    end

    assign busy = |early_valid;

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= link[PAIRS].valid;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        negative_error_reg <= link[PAIRS].neg;
        if (link[PAIRS].neg)
        begin
            root_value_reg <= NEG_ONE;
        end
        else
        begin
            root_value_reg <= OUT_W'(link[PAIRS].root);
        end
    end

    assign done           = done_reg;
    assign root_value     = root_value_reg;
    assign negative_error = negative_error_reg;

endmodule

// File: hw/rtl/fpsq_check.sv
`timescale 1ns / 1ps
`include "fixed_point_square_root_macros.svh"

module fpsq_check
    import fpsq_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [DATA_WIDTH-1:0]  radicand,
    input logic                          done,
    input logic signed [OUT_W-1:0]       root_value,
    input logic                          negative_error
);

    // an accepted word holds the block busy
    `FPSQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    // every accepted word comes out after the fixed latency
    `FPSQ_ASSERT_NOW(a_result_latency, start && !busy, ##LATENCY done)
    // a negative radicand comes out flagged
    `FPSQ_ASSERT_NOW(a_negative_flagged, start && !busy && radicand[DATA_WIDTH-1],
        ##LATENCY (done && negative_error))
    // a flagged word carries -1.0
    `FPSQ_ASSERT_NOW(a_negative_value, done && negative_error, root_value == NEG_ONE)
    // words are spaced, so successive strobes never run together
    `FPSQ_ASSERT_NEXT(a_single_strobe, done, !done)

endmodule

bind fixed_point_square_root fpsq_check u_fpsq_check (.*);
